// ----- src/record_sort_by_total_defines.svh -----
// ----------------------------------------------------------------------------
// Record sort by total: assertion macros
// Shared concurrent assertion forms used by the record sorter.
// ----------------------------------------------------------------------------
`ifndef RECORD_SORT_BY_TOTAL_DEFINES_SVH
`define RECORD_SORT_BY_TOTAL_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RSBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RSBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rsbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record sort by total: package
// Field widths, the record type, the sequencer states and score clamping.
// ----------------------------------------------------------------------------
package rsbt_pkg;

  localparam int unsigned ROLL_W      = 16;
  localparam int unsigned SCORE_W     = 14;
  localparam int unsigned TOTAL_W     = 16;
  localparam int unsigned AVG_W       = 14;
  localparam int unsigned SCORE_COUNT = 5;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned PROD_W      = 2 * TOTAL_W;
  localparam int unsigned AVG_SHIFT   = 18;

  localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(10000);
  // Reciprocal of five scaled by two to the eighteenth; exact for totals below 2^18.
  localparam logic [TOTAL_W-1:0] AVG_RECIP = TOTAL_W'(52429);

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [ROLL_W-1:0]  roll;
  } record_t;

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_ACCUM      = 8'b0000_0010,
    ST_WRITE      = 8'b0000_0100,
    ST_SORT_LOAD  = 8'b0000_1000,
    ST_SORT_FETCH = 8'b0001_0000,
    ST_SORT_CMP   = 8'b0010_0000,
    ST_SORT_PUT   = 8'b0100_0000,
    ST_EMIT       = 8'b1000_0000
  } state_e;

  function automatic logic [SCORE_W-1:0] clamp_score(input logic [SCORE_W-1:0] s);
    return (s > SCORE_MAX) ? SCORE_MAX : s;
  endfunction

endpackage

// ----- src/record_sort_by_total.sv -----
`timescale 1ns / 1ps
// An accepted item is summed in five adder passes and then written to the store if it has room.
// A new item is accepted only in the idle state after that write, so items do not overlap.
// Sorting is bounded by the single comparator that walks the one-read-port record store.
// Results follow at one per cycle once the sort ends, via the store read and output registers.
// Reset is asynchronous, active low, and empties the store; results cannot be stalled.
// ----------------------------------------------------------------------------
// Record sort by total
// Sums five scores per item into a record store, then exchange-sorts the
// stored records by total and emits identifier, total and average per record.
// ----------------------------------------------------------------------------
`include "record_sort_by_total_defines.svh"

module record_sort_by_total
  import rsbt_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [ROLL_W-1:0]  roll_i,
  input  logic [SCORE_W-1:0] score_a_i,
  input  logic [SCORE_W-1:0] score_b_i,
  input  logic [SCORE_W-1:0] score_c_i,
  input  logic [SCORE_W-1:0] score_d_i,
  input  logic [SCORE_W-1:0] score_e_i,
  input  logic               last_i,
  output logic               result_valid_o,
  output logic [ROLL_W-1:0]  out_roll_o,
  output logic [TOTAL_W-1:0] total_o,
  output logic [AVG_W-1:0]   average_o,
  output logic               end_of_run_o
);

  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [TOTAL_W-1:0] sum_q, sum_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      p_q, p_d;
  logic [CW-1:0]      cmp_q, cmp_d;
  logic [CW-1:0]      emit_q, emit_d;
  record_t            key_q, key_d;
  logic               rd_vld_q, rd_vld_d;
  logic               rd_end_q, rd_end_d;
  logic               out_valid_q, out_end_q;

  logic [SCORE_W-1:0] scores_q [SCORE_COUNT];
  logic [ROLL_W-1:0]  roll_q;
  logic               last_q;

  record_t            mem_q [MAX_RECORDS];
  record_t            rd_data_q;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  record_t            mem_wdata;

  logic [CW-1:0]      p_inc, cmp_inc, emit_inc, count_inc, count_dec;
  logic [PROD_W-1:0]  prod;
  logic [ROLL_W-1:0]  out_roll_q;
  logic [TOTAL_W-1:0] out_total_q;
  logic [AVG_W-1:0]   out_avg_q;
  logic               accept;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign p_inc     = p_q + CW'(1);
  assign cmp_inc   = cmp_q + CW'(1);
  assign emit_inc  = emit_q + CW'(1);
  assign count_inc = count_q + CW'(1);
  assign count_dec = count_q - CW'(1);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    count_d   = count_q;
    p_d       = p_q;
    cmp_d     = cmp_q;
    emit_d    = emit_q;
    key_d     = key_q;
    mem_we    = 1'b0;
    mem_waddr = count_q[AW-1:0];
    mem_wdata = key_q;
    rd_addr   = p_q[AW-1:0];
    rd_vld_d  = 1'b0;
    rd_end_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_ACCUM;
          idx_d   = '0;
          sum_d   = '0;
        end
      end
      ST_ACCUM: begin
        sum_d = sum_q + TOTAL_W'(clamp_score(scores_q[idx_q]));
        if (idx_q == IDX_W'(SCORE_COUNT - 1)) begin
          state_d = ST_WRITE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_WRITE: begin
        if (count_q < CW'(MAX_RECORDS)) begin
          mem_we    = 1'b1;
          mem_waddr = count_q[AW-1:0];
          mem_wdata = '{total: sum_q, roll: roll_q};
          count_d   = count_inc;
        end
        if (!last_q) begin
          state_d = ST_IDLE;
        end else begin
          p_d    = '0;
          emit_d = '0;
          if (count_d >= CW'(2)) begin
            state_d = ST_SORT_LOAD;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SORT_LOAD: begin
        rd_addr = p_q[AW-1:0];
        state_d = ST_SORT_FETCH;
      end
      ST_SORT_FETCH: begin
        key_d   = rd_data_q;
        rd_addr = p_inc[AW-1:0];
        cmp_d   = p_inc;
        state_d = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        if (key_q.total > rd_data_q.total) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_q[AW-1:0];
          mem_wdata = key_q;
          key_d     = rd_data_q;
        end
        if (cmp_q == count_dec) begin
          state_d = ST_SORT_PUT;
        end else begin
          rd_addr = cmp_inc[AW-1:0];
          cmp_d   = cmp_inc;
        end
      end
      ST_SORT_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = p_q[AW-1:0];
        mem_wdata = key_q;
        if (p_inc == count_dec) begin
          emit_d  = '0;
          state_d = ST_EMIT;
        end else begin
          p_d     = p_inc;
          rd_addr = p_inc[AW-1:0];
          state_d = ST_SORT_FETCH;
        end
      end
      ST_EMIT: begin
        rd_addr  = emit_q[AW-1:0];
        rd_vld_d = 1'b1;
        if (emit_q == count_dec) begin
          rd_end_d = 1'b1;
          count_d  = '0;
          state_d  = ST_IDLE;
        end else begin
          emit_d = emit_inc;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      p_q         <= '0;
      cmp_q       <= '0;
      emit_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_end_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_end_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      p_q         <= p_d;
      cmp_q       <= cmp_d;
      emit_q      <= emit_d;
      rd_vld_q    <= rd_vld_d;
      rd_end_q    <= rd_end_d;
      out_valid_q <= rd_vld_q;
      out_end_q   <= rd_vld_q && rd_end_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    key_q <= key_d;
    if (accept) begin
      roll_q      <= roll_i;
      last_q      <= last_i;
      scores_q[0] <= score_a_i;
      scores_q[1] <= score_b_i;
      scores_q[2] <= score_c_i;
      scores_q[3] <= score_d_i;
      scores_q[4] <= score_e_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign prod = PROD_W'(rd_data_q.total) * PROD_W'(AVG_RECIP);

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      out_roll_q  <= rd_data_q.roll;
      out_total_q <= rd_data_q.total;
      out_avg_q   <= prod[AVG_SHIFT +: AVG_W];
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign out_roll_o     = out_roll_q;
  assign total_o        = out_total_q;
  assign average_o      = out_avg_q;
  assign end_of_run_o   = out_end_q;

  `RSBT_ASSERT_NXT(a_accept_accum, clk_i, rst_ni, accept, state_q == ST_ACCUM, "Accepted item did not start accumulation.")
  `RSBT_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(MAX_RECORDS), "Record count exceeds the store depth.")
  `RSBT_ASSERT_IMP(a_cmp_in_set, clk_i, rst_ni, state_q == ST_SORT_CMP, (cmp_q < count_q) && (p_q < cmp_q), "Compare index outside the pass.")
  `RSBT_ASSERT_NXT(a_run_gap, clk_i, rst_ni, result_valid_o && end_of_run_o, !result_valid_o, "Result item followed the end of a run.")

endmodule
